// ----- rtl/core/vgp_pkg.sv -----
// Shared types and constants for the voxel gradient parameter block.
// No dependencies; the front end, divider, root and top-level modules refer to it by scoped names.
`default_nettype none

package vgp_pkg;

  // Fixed field widths
  localparam int COORD_W    = 14;
  localparam int SIZE_W     = 15;
  localparam int MODE_W     = 4;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 15;
  localparam int IN_TW      = 48;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_X = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SIZE_Z = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_MODE   = 2'd3;

  // Gradient modes
  localparam logic [MODE_W-1:0] MODE_CONST  = 4'd0;
  localparam logic [MODE_W-1:0] MODE_POS_X  = 4'd1;
  localparam logic [MODE_W-1:0] MODE_POS_Y  = 4'd2;
  localparam logic [MODE_W-1:0] MODE_POS_Z  = 4'd3;
  localparam logic [MODE_W-1:0] MODE_NEG_X  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_NEG_Y  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_NEG_Z  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_CENTER = 4'd7;

  // How the final stage forms the result
  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_ONE,
    KIND_AXIS,
    KIND_CENTER
  } kind_t;

  // Side information that rides along the pipeline
  typedef struct packed {
    kind_t kind;
    logic  clamped;
    logic  eq;
  } side_t;

endpackage

`default_nettype wire

// ----- rtl/core/vgp_front.sv -----
// Front end: axis distances, squares, sums and mode decode in three stages.
// Depends on vgp_pkg.
`default_nettype none

module vgp_front #(
  parameter int SW = 15,
  parameter int DW = 15,
  parameter int AW = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [vgp_pkg::COORD_W-1:0]   in_coord_x,
  input  wire [vgp_pkg::COORD_W-1:0]   in_coord_y,
  input  wire [vgp_pkg::COORD_W-1:0]   in_coord_z,
  input  wire [SW-1:0]                 size_x,
  input  wire [SW-1:0]                 size_y,
  input  wire [SW-1:0]                 size_z,
  input  wire [vgp_pkg::MODE_W-1:0]    mode,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [AW-1:0]                out_num,
  output logic [AW-1:0]                out_den,
  output vgp_pkg::side_t               out_side
);

  localparam int SQW = 2 * DW;
  localparam int SSW = 2 * SW;

  logic [2:0] v_r;
  logic [3:0] chain;

  // Stage 1 registers
  logic [DW-1:0]                d1_r [3];
  logic [SW-1:0]                s1_r [3];
  logic [vgp_pkg::COORD_W-1:0]  axc1_r;
  logic [SW-1:0]                axs1_r;
  logic                         pos1_r;
  logic [vgp_pkg::MODE_W-1:0]   mode1_r;

  // Stage 2 registers
  logic [SQW-1:0]               da2_r [3];
  logic [SSW-1:0]               sb2_r [3];
  logic                         gt2_r;
  logic [DW-1:0]                num2_r;
  logic [SW-1:0]                den2_r;
  logic [vgp_pkg::MODE_W-1:0]   mode2_r;

  // Stage 3 registers
  logic [AW-1:0]                num3_r;
  logic [AW-1:0]                den3_r;
  vgp_pkg::side_t               side3_r;

  logic [DW-1:0]                d1_nxt [3];
  logic [vgp_pkg::COORD_W-1:0]  axc1_nxt;
  logic [SW-1:0]                axs1_nxt;
  logic                         pos1_nxt;
  logic [SQW-1:0]               da2_nxt [3];
  logic [SSW-1:0]               sb2_nxt [3];
  logic                         gt2_nxt;
  logic [DW-1:0]                num2_nxt;
  logic [AW-1:0]                num3_nxt;
  logic [AW-1:0]                den3_nxt;
  vgp_pkg::side_t               side3_nxt;
  logic [AW-1:0]                sum_a;
  logic [AW-1:0]                sum_b;

  logic [vgp_pkg::COORD_W-1:0]  cin [3];
  logic [SW-1:0]                sin [3];

  assign cin[0] = in_coord_x;
  assign cin[1] = in_coord_y;
  assign cin[2] = in_coord_z;
  assign sin[0] = size_x;
  assign sin[1] = size_y;
  assign sin[2] = size_z;

  // Back-pressure: a stage loads when empty or when the next one moves
  always_comb begin
    chain[3] = out_ready;
    for (int k = 2; k >= 0; k--) begin
      chain[k] = !v_r[k] | chain[k+1];
    end
  end
  assign in_ready  = chain[0];
  assign out_valid = v_r[2];

  // Stage 1: distance of twice the coordinate from the size, axis pick
  always_comb begin
    logic [DW:0] t;
    logic [DW:0] se;
    for (int i = 0; i < 3; i++) begin
      t  = (DW+1)'({cin[i], 1'b0});
      se = (DW+1)'(sin[i]);
      d1_nxt[i] = (t >= se) ? DW'(t - se) : DW'(se - t);
    end
    unique case (mode)
      vgp_pkg::MODE_POS_X, vgp_pkg::MODE_NEG_X: begin
        axc1_nxt = in_coord_x;
        axs1_nxt = size_x;
      end
      vgp_pkg::MODE_POS_Y, vgp_pkg::MODE_NEG_Y: begin
        axc1_nxt = in_coord_y;
        axs1_nxt = size_y;
      end
      default: begin
        axc1_nxt = in_coord_z;
        axs1_nxt = size_z;
      end
    endcase
    pos1_nxt = (mode == vgp_pkg::MODE_POS_X) || (mode == vgp_pkg::MODE_POS_Y) ||
               (mode == vgp_pkg::MODE_POS_Z);
  end

  // Stage 2: squares, axis overrun check and numerator
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      da2_nxt[i] = SQW'(d1_r[i]) * SQW'(d1_r[i]);
      sb2_nxt[i] = SSW'(s1_r[i]) * SSW'(s1_r[i]);
    end
    gt2_nxt  = DW'(axc1_r) > DW'(axs1_r);
    num2_nxt = pos1_r ? (DW'(axs1_r) - DW'(axc1_r)) : DW'(axc1_r);
  end

  // Stage 3: sums, compare and divider operands
  always_comb begin
    sum_a = AW'(da2_r[0]) + AW'(da2_r[1]) + AW'(da2_r[2]);
    sum_b = AW'(sb2_r[0]) + AW'(sb2_r[1]) + AW'(sb2_r[2]);
    num3_nxt          = AW'(num2_r);
    den3_nxt          = AW'(den2_r);
    side3_nxt.kind    = vgp_pkg::KIND_ZERO;
    side3_nxt.clamped = 1'b0;
    side3_nxt.eq      = AW'(num2_r) == AW'(den2_r);
    unique case (mode2_r)
      vgp_pkg::MODE_CONST: begin
        side3_nxt.kind = vgp_pkg::KIND_ONE;
      end
      vgp_pkg::MODE_POS_X, vgp_pkg::MODE_POS_Y, vgp_pkg::MODE_POS_Z: begin
        side3_nxt.kind    = gt2_r ? vgp_pkg::KIND_ZERO : vgp_pkg::KIND_AXIS;
        side3_nxt.clamped = gt2_r;
      end
      vgp_pkg::MODE_NEG_X, vgp_pkg::MODE_NEG_Y, vgp_pkg::MODE_NEG_Z: begin
        side3_nxt.kind    = gt2_r ? vgp_pkg::KIND_ONE : vgp_pkg::KIND_AXIS;
        side3_nxt.clamped = gt2_r;
      end
      vgp_pkg::MODE_CENTER: begin
        num3_nxt          = sum_a;
        den3_nxt          = sum_b;
        side3_nxt.eq      = sum_a == sum_b;
        side3_nxt.kind    = (sum_a > sum_b) ? vgp_pkg::KIND_ZERO : vgp_pkg::KIND_CENTER;
        side3_nxt.clamped = sum_a > sum_b;
      end
      default: begin
        side3_nxt.kind = vgp_pkg::KIND_ZERO;
      end
    endcase
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (chain[0]) v_r[0] <= in_valid;
      if (chain[1]) v_r[1] <= v_r[0];
      if (chain[2]) v_r[2] <= v_r[1];
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (chain[0]) begin
      d1_r    <= d1_nxt;
      s1_r    <= sin;
      axc1_r  <= axc1_nxt;
      axs1_r  <= axs1_nxt;
      pos1_r  <= pos1_nxt;
      mode1_r <= mode;
    end
    if (chain[1]) begin
      da2_r   <= da2_nxt;
      sb2_r   <= sb2_nxt;
      gt2_r   <= gt2_nxt;
      num2_r  <= num2_nxt;
      den2_r  <= axs1_r;
      mode2_r <= mode1_r;
    end
    if (chain[2]) begin
      num3_r  <= num3_nxt;
      den3_r  <= den3_nxt;
      side3_r <= side3_nxt;
    end
  end

  assign out_num  = num3_r;
  assign out_den  = den3_r;
  assign out_side = side3_r;

endmodule

`default_nettype wire

// ----- rtl/core/vgp_div.sv -----
// Pipelined restoring divider: QB fraction bits of num/den, num < den.
// Four quotient bits per stage. Depends on vgp_pkg.
`default_nettype none

module vgp_div #(
  parameter int W  = 32,
  parameter int QB = 34
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_ready,
  input  wire [W-1:0]     in_num,
  input  wire [W-1:0]     in_den,
  input  vgp_pkg::side_t  in_side,
  output logic            out_valid,
  input  wire             out_ready,
  output logic [QB-1:0]   out_quo,
  output vgp_pkg::side_t  out_side
);

  localparam int SPS = 4;
  localparam int NS  = (QB + SPS - 1) / SPS;

  logic [NS-1:0]   v_r;
  logic [NS:0]     chain;
  logic [W-1:0]    rem_r  [NS];
  logic [W-1:0]    den_r  [NS];
  logic [QB-1:0]   quo_r  [NS];
  vgp_pkg::side_t  side_r [NS];
  logic [W-1:0]    rem_nxt [NS];
  logic [QB-1:0]   quo_nxt [NS];
  logic [W-1:0]    src_rem [NS];
  logic [W-1:0]    src_den [NS];
  logic [QB-1:0]   src_quo [NS];
  vgp_pkg::side_t  src_side [NS];

  // Back-pressure chain
  always_comb begin
    chain[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      chain[k] = !v_r[k] | chain[k+1];
    end
  end
  assign in_ready  = chain[0];
  assign out_valid = v_r[NS-1];

  genvar g;
  generate
    for (g = 0; g < NS; g++) begin : g_stage
      if (g == 0) begin : g_first
        assign src_rem[g]  = in_num;
        assign src_den[g]  = in_den;
        assign src_quo[g]  = '0;
        assign src_side[g] = in_side;
      end else begin : g_rest
        assign src_rem[g]  = rem_r[g-1];
        assign src_den[g]  = den_r[g-1];
        assign src_quo[g]  = quo_r[g-1];
        assign src_side[g] = side_r[g-1];
      end

      // Shift, compare and subtract, one quotient bit a step
      always_comb begin
        logic [W-1:0]  r;
        logic [QB-1:0] q;
        logic [W:0]    sh;
        r = src_rem[g];
        q = src_quo[g];
        for (int j = 0; j < SPS; j++) begin
          if (g * SPS + j < QB) begin
            sh = {r, 1'b0};
            if (sh >= {1'b0, src_den[g]}) begin
              r = W'(sh - {1'b0, src_den[g]});
              q = {q[QB-2:0], 1'b1};
            end else begin
              r = sh[W-1:0];
              q = {q[QB-2:0], 1'b0};
            end
          end
        end
        rem_nxt[g] = r;
        quo_nxt[g] = q;
      end

      always_ff @(posedge clk) begin
        if (chain[g]) begin
          rem_r[g]  <= rem_nxt[g];
          den_r[g]  <= src_den[g];
          quo_r[g]  <= quo_nxt[g];
          side_r[g] <= src_side[g];
        end
      end
    end
  endgenerate

  // Valid bits advance with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (chain[k]) v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign out_quo  = quo_r[NS-1];
  assign out_side = side_r[NS-1];

endmodule

`default_nettype wire

// ----- rtl/core/vgp_sqrt.sv -----
// Pipelined integer square root of the divider quotient, four result bits
// per stage; carries the axis quotient alongside. Depends on vgp_pkg.
`default_nettype none

module vgp_sqrt #(
  parameter int QB = 34,
  parameter int F  = 16
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_ready,
  input  wire [QB-1:0]    in_quo,
  input  vgp_pkg::side_t  in_side,
  output logic            out_valid,
  input  wire             out_ready,
  output logic [F+1:0]    out_root,
  output logic [F+1:0]    out_axq,
  output vgp_pkg::side_t  out_side
);

  localparam int VW  = QB + 1;
  localparam int RW  = QB + 2;
  localparam int NST = F + 2;
  localparam int SPS = 4;
  localparam int NS  = (NST + SPS - 1) / SPS;

  logic [NS-1:0]   v_r;
  logic [NS:0]     chain;
  logic [VW-1:0]   val_r  [NS];
  logic [RW-1:0]   res_r  [NS];
  logic [F+1:0]    axq_r  [NS];
  vgp_pkg::side_t  side_r [NS];
  logic [VW-1:0]   val_nxt [NS];
  logic [RW-1:0]   res_nxt [NS];
  logic [VW-1:0]   src_val [NS];
  logic [RW-1:0]   src_res [NS];
  logic [F+1:0]    src_axq [NS];
  vgp_pkg::side_t  src_side [NS];
  logic [VW-1:0]   val0;
  logic [F+1:0]    axq0;

  // Exact ratio stands for a quotient of one
  assign val0 = in_side.eq ? (VW'(1) << QB) : VW'(in_quo);
  assign axq0 = in_side.eq ? ((F+2)'(1) << (F + 1)) : (F+2)'(in_quo[QB-1 -: F+1]);

  always_comb begin
    chain[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      chain[k] = !v_r[k] | chain[k+1];
    end
  end
  assign in_ready  = chain[0];
  assign out_valid = v_r[NS-1];

  genvar g;
  generate
    for (g = 0; g < NS; g++) begin : g_stage
      if (g == 0) begin : g_first
        assign src_val[g]  = val0;
        assign src_res[g]  = '0;
        assign src_axq[g]  = axq0;
        assign src_side[g] = in_side;
      end else begin : g_rest
        assign src_val[g]  = val_r[g-1];
        assign src_res[g]  = res_r[g-1];
        assign src_axq[g]  = axq_r[g-1];
        assign src_side[g] = side_r[g-1];
      end

      // Digit-by-digit root, trial bit falling by a factor of four a step
      always_comb begin
        logic [VW-1:0] v;
        logic [RW-1:0] r;
        logic [RW-1:0] bitc;
        logic [RW-1:0] trial;
        int            idx;
        v = src_val[g];
        r = src_res[g];
        for (int j = 0; j < SPS; j++) begin
          idx = g * SPS + j;
          if (idx < NST) begin
            bitc  = RW'(1) << (2 * (NST - 1 - idx));
            trial = r + bitc;
            if (RW'(v) >= trial) begin
              v = v - VW'(trial);
              r = (r >> 1) + bitc;
            end else begin
              r = r >> 1;
            end
          end
        end
        val_nxt[g] = v;
        res_nxt[g] = r;
      end

      always_ff @(posedge clk) begin
        if (chain[g]) begin
          val_r[g]  <= val_nxt[g];
          res_r[g]  <= res_nxt[g];
          axq_r[g]  <= src_axq[g];
          side_r[g] <= src_side[g];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (chain[k]) v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  assign out_root = res_r[NS-1][F+1:0];
  assign out_axq  = axq_r[NS-1];
  assign out_side = side_r[NS-1];

endmodule

`default_nettype wire

// ----- rtl/core/voxel_gradient_parameter.sv -----
// Top level of the voxel gradient parameter block: configuration registers,
// front end, divider, root pipeline and output register. Depends on vgp_pkg.
//
//   channel  dir  beat contents
//   in_*     in   tdata: coord_x, coord_y, coord_z (14 bits each, lowest first)
//   out_*    out  tdata: ramp_param (FRAC_BITS+1 bits); tuser: clamped
//   cfg_*    in   one register write per cycle while cfg_wr_en is high
//
// One beat enters per cycle while in_tready is high; a beat passes the three
// front-end stages, the divider and root pipelines (four bits per stage) and
// the output register. Every stage holds its own valid bit and loads when
// empty or when the next stage moves, so a stalled output holds its beat while
// bubbles upstream keep filling. rst_n is synchronous; registers come up at
// size 4 on each axis and constant mode.
`default_nettype none

module voxel_gradient_parameter #(
  parameter int MAX_SIZE  = 16384,
  parameter int FRAC_BITS = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [vgp_pkg::IN_TW-1:0]            in_tdata,   // coord_x, coord_y, coord_z
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [((FRAC_BITS+8)/8)*8-1:0]       out_tdata,  // ramp_param
  output logic                                 out_tuser,  // clamped
  input  wire                                  cfg_wr_en,
  input  wire  [vgp_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  wire  [vgp_pkg::CFG_DATA_W-1:0]       cfg_wr_data
);

  localparam int OUT_TW = ((FRAC_BITS + 8) / 8) * 8;
  localparam int SW     = $clog2(MAX_SIZE + 1);
  localparam int DW     = (SW > vgp_pkg::COORD_W + 1) ? SW : vgp_pkg::COORD_W + 1;
  localparam int AW     = 2 * DW + 2;
  localparam int QB     = 2 * FRAC_BITS + 2;
  localparam logic [FRAC_BITS:0] ONE_VAL = {1'b1, {FRAC_BITS{1'b0}}};

  logic [vgp_pkg::SIZE_W-1:0] size_r [3];
  logic [vgp_pkg::MODE_W-1:0] mode_r;
  logic [SW-1:0]              eff    [3];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r[0] <= vgp_pkg::SIZE_W'(4);
      size_r[1] <= vgp_pkg::SIZE_W'(4);
      size_r[2] <= vgp_pkg::SIZE_W'(4);
      mode_r    <= vgp_pkg::MODE_CONST;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        vgp_pkg::CFG_SIZE_X: size_r[0] <= cfg_wr_data;
        vgp_pkg::CFG_SIZE_Y: size_r[1] <= cfg_wr_data;
        vgp_pkg::CFG_SIZE_Z: size_r[2] <= cfg_wr_data;
        vgp_pkg::CFG_MODE:   mode_r    <= cfg_wr_data[vgp_pkg::MODE_W-1:0];
        default:             mode_r    <= mode_r;
      endcase
    end
  end

  // Effective size: zero acts as one, saturate at MAX_SIZE
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (size_r[i] == '0) begin
        eff[i] = SW'(1);
      end else if (32'(size_r[i]) > 32'(MAX_SIZE)) begin
        eff[i] = SW'(MAX_SIZE);
      end else begin
        eff[i] = SW'(size_r[i]);
      end
    end
  end

  logic            fe_valid, fe_ready;
  logic [AW-1:0]   fe_num, fe_den;
  vgp_pkg::side_t  fe_side;
  logic            dv_valid, dv_ready;
  logic [QB-1:0]   dv_quo;
  vgp_pkg::side_t  dv_side;
  logic            sq_valid, sq_ready;
  logic [FRAC_BITS+1:0] sq_root, sq_axq;
  vgp_pkg::side_t  sq_side;

  vgp_front #(.SW(SW), .DW(DW), .AW(AW)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_coord_x (in_tdata[vgp_pkg::COORD_W-1:0]),
    .in_coord_y (in_tdata[2*vgp_pkg::COORD_W-1:vgp_pkg::COORD_W]),
    .in_coord_z (in_tdata[3*vgp_pkg::COORD_W-1:2*vgp_pkg::COORD_W]),
    .size_x     (eff[0]),
    .size_y     (eff[1]),
    .size_z     (eff[2]),
    .mode       (mode_r),
    .out_valid  (fe_valid),
    .out_ready  (fe_ready),
    .out_num    (fe_num),
    .out_den    (fe_den),
    .out_side   (fe_side)
  );

  vgp_div #(.W(AW), .QB(QB)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fe_valid),
    .in_ready  (fe_ready),
    .in_num    (fe_num),
    .in_den    (fe_den),
    .in_side   (fe_side),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  vgp_sqrt #(.QB(QB), .F(FRAC_BITS)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_quo    (dv_quo),
    .in_side   (dv_side),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_root  (sq_root),
    .out_axq   (sq_axq),
    .out_side  (sq_side)
  );

  // Output stage: round, saturate and select by kind
  logic                 out_valid_r;
  logic [FRAC_BITS:0]   out_data_r;
  logic                 out_clamp_r;
  logic [FRAC_BITS:0]   val_nxt;
  logic [FRAC_BITS+1:0] m_inc;
  logic [FRAC_BITS+1:0] a_inc;
  logic [FRAC_BITS:0]   q_ctr;

  assign sq_ready = !out_valid_r | out_tready;

  always_comb begin
    m_inc = sq_root + (FRAC_BITS+2)'(1);
    a_inc = sq_axq + (FRAC_BITS+2)'(1);
    q_ctr = m_inc[FRAC_BITS+1:1];
    if (q_ctr > ONE_VAL) q_ctr = ONE_VAL;
    unique case (sq_side.kind)
      vgp_pkg::KIND_ZERO:   val_nxt = '0;
      vgp_pkg::KIND_ONE:    val_nxt = ONE_VAL;
      vgp_pkg::KIND_AXIS:   val_nxt = a_inc[FRAC_BITS+1:1];
      vgp_pkg::KIND_CENTER: val_nxt = ONE_VAL - q_ctr;
      default:              val_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (sq_ready) begin
      out_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_ready) begin
      out_data_r  <= val_nxt;
      out_clamp_r <= sq_side.clamped;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TW'(out_data_r);
  assign out_tuser  = out_clamp_r;

endmodule

`default_nettype wire

// ----- rtl/core/vgp_checker.sv -----
// Port-level checks on the result channel of voxel_gradient_parameter,
// bound to the top level. Depends on nothing but the top level's ports.
`default_nettype none

module vgp_checker #(
  parameter int FRAC_BITS = 16
) (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                out_tvalid,
  input wire                                out_tready,
  input wire [((FRAC_BITS+8)/8)*8-1:0]      out_tdata,
  input wire                                out_tuser
);

  localparam logic [FRAC_BITS:0] ONE_VAL = {1'b1, {FRAC_BITS{1'b0}}};

  // The parameter never exceeds one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[FRAC_BITS:0] <= ONE_VAL)
    else $error("ramp parameter above one");

  // A saturated beat sits at one of the two ends
  a_clamp_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      (out_tdata[FRAC_BITS:0] == '0 || out_tdata[FRAC_BITS:0] == ONE_VAL))
    else $error("clamped beat not at an end of the range");

  // A stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result beat changed");

  // Nothing comes out straight after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind voxel_gradient_parameter vgp_checker #(.FRAC_BITS(FRAC_BITS)) u_vgp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ----- verif/tb_voxel_gradient_parameter.sv -----
// Testbench for voxel_gradient_parameter: drives coordinate beats through the
// stream ports, predicts each ramp parameter and checks it. Depends on vgp_pkg.
`timescale 1ns / 100ps

class ramp_scoreboard;
  logic [16:0] ramp_q[$];
  logic        clamp_q[$];
  int          errors;
  int          checked;

  function new();
    errors = 0;
    checked = 0;
  endfunction

  // Map a size register to the usable range: zero acts as one, saturate at 16384.
  function automatic longint unsigned grid_size(logic [14:0] s);
    if (s == 0) return 1;
    if (s > 16384) return 16384;
    return 64'(s);
  endfunction

  function automatic longint unsigned ramp_div(longint unsigned num, longint unsigned den);
    return ((num << 17) + den) / (den * 2);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned sq_offset(longint unsigned c, longint unsigned s);
    longint unsigned t, d;
    t = c * 2;
    d = (t >= s) ? t - s : s - t;
    return d * d;
  endfunction

  // Note an accepted coordinate beat and queue its expected result.
  function void note_voxel(logic [13:0] cx, logic [13:0] cy, logic [13:0] cz,
                           logic [14:0] sx, logic [14:0] sy, logic [14:0] sz,
                           logic [3:0] mode);
    longint unsigned c[3], s[3], a, b, quo, rem, m, q, val;
    logic clp;
    int ax;
    c[0] = 64'(cx); c[1] = 64'(cy); c[2] = 64'(cz);
    s[0] = grid_size(sx); s[1] = grid_size(sy); s[2] = grid_size(sz);
    val = 0;
    clp = 0;
    case (mode)
      vgp_pkg::MODE_CONST: val = 65536;
      vgp_pkg::MODE_POS_X, vgp_pkg::MODE_POS_Y, vgp_pkg::MODE_POS_Z: begin
        ax = int'(mode - vgp_pkg::MODE_POS_X);
        if (c[ax] > s[ax]) clp = 1;
        else val = ramp_div(s[ax] - c[ax], s[ax]);
      end
      vgp_pkg::MODE_NEG_X, vgp_pkg::MODE_NEG_Y, vgp_pkg::MODE_NEG_Z: begin
        ax = int'(mode - vgp_pkg::MODE_NEG_X);
        if (c[ax] > s[ax]) begin
          val = 65536;
          clp = 1;
        end else begin
          val = ramp_div(c[ax], s[ax]);
        end
      end
      vgp_pkg::MODE_CENTER: begin
        a = sq_offset(c[0], s[0]) + sq_offset(c[1], s[1]) + sq_offset(c[2], s[2]);
        b = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
        if (a > b) begin
          clp = 1;
        end else begin
          quo = 0;
          rem = a;
          if (a == b) quo = 64'd1 << 34;
          else begin
            for (int i = 0; i < 34; i++) begin
              rem <<= 1;
              quo <<= 1;
              if (rem >= b) begin
                rem -= b;
                quo |= 1;
              end
            end
          end
          m = int_sqrt(quo);
          q = (m + 1) / 2;
          if (q > 65536) q = 65536;
          val = 65536 - q;
        end
      end
      default: val = 0;
    endcase
    ramp_q = {ramp_q, val[16:0]};
    clamp_q = {clamp_q, clp};
  endfunction

  // Compare one result beat against the oldest expectation.
  function void check_ramp(logic [16:0] ramp, logic clp);
    logic [16:0] er;
    logic ec;
    if (ramp_q.size() == 0) begin
      $error("result beat with no expectation: ramp_param %0d", ramp);
      errors++;
      return;
    end
    er = ramp_q.pop_front();
    ec = clamp_q.pop_front();
    checked++;
    if (ramp !== er) begin
      $error("ramp_param mismatch: expected %0d actual %0d", er, ramp);
      errors++;
    end
    if (clp !== ec) begin
      $error("clamped mismatch: expected %0d actual %0d", ec, clp);
      errors++;
    end
  endfunction

  function int pending();
    return ramp_q.size();
  endfunction
endclass

module tb_voxel_gradient_parameter;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN    = 40;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  wire         in_tready;
  logic [47:0] in_tdata;
  wire         out_tvalid;
  logic        out_tready;
  wire  [23:0] out_tdata;
  wire         out_tuser;
  logic        cfg_wr_en;
  logic [1:0]  cfg_addr;
  logic [14:0] cfg_wr_data;

  logic [14:0] reg_sx, reg_sy, reg_sz;
  logic [3:0]  reg_mode;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_off;
  int          quiet_cycles;
  int          sent;
  bit          timed_out;
  ramp_scoreboard board;

  voxel_gradient_parameter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Receiver: random stalls, plus a long counted hold-off on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check result beats and watch for a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_ramp(out_tdata[16:0], out_tuser);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG) begin
      $display("timeout with %0d results outstanding", board.pending());
      $display("voxel_gradient_parameter verification failed");
      $finish;
    end
  end

  // Raise the write strobe for one register; the caller drops it.
  task automatic write_reg(logic [1:0] idx, logic [14:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    case (idx)
      vgp_pkg::CFG_SIZE_X: reg_sx = val;
      vgp_pkg::CFG_SIZE_Y: reg_sy = val;
      vgp_pkg::CFG_SIZE_Z: reg_sz = val;
      default:             reg_mode = val[3:0];
    endcase
  endtask

  // Drop the input, wait for every expected result, then let the pipeline settle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_grid(logic [14:0] sx, logic [14:0] sy, logic [14:0] sz,
                          logic [3:0] mode);
    drain();
    write_reg(vgp_pkg::CFG_SIZE_X, sx);
    write_reg(vgp_pkg::CFG_SIZE_Y, sy);
    write_reg(vgp_pkg::CFG_SIZE_Z, sz);
    write_reg(vgp_pkg::CFG_MODE, {11'd0, mode});
    cfg_wr_en <= 1'b0;
  endtask

  // Offer one coordinate beat and hold it until accepted.
  task automatic send_voxel(logic [13:0] cx, logic [13:0] cy, logic [13:0] cz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, cz, cy, cx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_voxel(cx, cy, cz, reg_sx, reg_sy, reg_sz, reg_mode);
    sent++;
  endtask

  // Coordinate mostly inside the grid, sometimes at or past the edge.
  function automatic logic [13:0] pick_coord(logic [14:0] sz);
    int unsigned r, lim;
    r = $urandom_range(99);
    lim = (sz == 0) ? 1 : (sz > 16384 ? 16384 : sz);
    if (r < 75) return 14'($urandom_range(lim - 1));
    if (r < 85) return (lim > 16383) ? 14'h3FFF : lim[13:0];
    return 14'($urandom);
  endfunction

  function automatic logic [14:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 15'($urandom_range(1, 64));
    if (r < 70) return 15'($urandom_range(1, 16384));
    if (r < 80) return 15'd16384;
    if (r < 88) return 15'd1;
    if (r < 94) return 15'd0;
    return 15'($urandom_range(16385, 32767));
  endfunction

  task automatic random_phase(int count, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0)
        set_grid(pick_size(), pick_size(), pick_size(), 4'($urandom_range(15)));
      send_voxel(pick_coord(reg_sx), pick_coord(reg_sy), pick_coord(reg_sz));
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_addr = '0;
    cfg_wr_data = '0;
    hold_off = 0;
    quiet_cycles = 0;
    sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    reg_sx = 15'd4; reg_sy = 15'd4; reg_sz = 15'd4; reg_mode = vgp_pkg::MODE_CONST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, then every mode but MODE_POS_Y at the extremes.
    send_voxel(14'd0, 14'd0, 14'd0);
    send_voxel(14'h3FFF, 14'h3FFF, 14'h3FFF);
    set_grid(15'd4, 15'd4, 15'd4, vgp_pkg::MODE_POS_X);
    send_voxel(14'd4, 14'd0, 14'd0);     // coordinate equal to size
    send_voxel(14'd5, 14'd0, 14'd0);     // beyond size
    send_voxel(14'd1, 14'd0, 14'd0);
    set_grid(15'd3, 15'd7, 15'd0, vgp_pkg::MODE_NEG_Y);
    send_voxel(14'd0, 14'd7, 14'd0);
    send_voxel(14'd0, 14'd8, 14'd0);
    send_voxel(14'd0, 14'd3, 14'd0);
    set_grid(15'd0, 15'd7, 15'd0, vgp_pkg::MODE_POS_Z); // size zero acts as one
    send_voxel(14'd0, 14'd0, 14'd1);
    send_voxel(14'd0, 14'd0, 14'd0);
    set_grid(15'd32767, 15'd16384, 15'd16384, vgp_pkg::MODE_NEG_X); // above the maximum
    send_voxel(14'h3FFF, 14'd0, 14'd0);
    set_grid(15'd8, 15'd8, 15'd8, vgp_pkg::MODE_CENTER);
    send_voxel(14'd4, 14'd4, 14'd4);     // grid centre
    send_voxel(14'd0, 14'd0, 14'd0);     // corner exactly
    send_voxel(14'd9, 14'd0, 14'd0);     // farther than the corner
    send_voxel(14'd2, 14'd5, 14'd7);
    set_grid(15'd16384, 15'd16384, 15'd16384, vgp_pkg::MODE_CENTER);
    send_voxel(14'h3FFF, 14'h3FFF, 14'h3FFF);
    send_voxel(14'd8192, 14'd8192, 14'd8192);
    set_grid(15'd8, 15'd8, 15'd8, 4'd8);
    send_voxel(14'd1, 14'd2, 14'd3);
    set_grid(15'd8, 15'd8, 15'd8, 4'd15);
    send_voxel(14'd1, 14'd2, 14'd3);
    set_grid(15'd8, 15'd8, 15'd8, vgp_pkg::MODE_NEG_Z);
    send_voxel(14'd0, 14'd0, 14'd8);

    // Random phases with several idling patterns.
    random_phase(250, 0, 0);
    random_phase(250, 59, 0);
    random_phase(250, 0, 59);
    random_phase(250, 33, 33);

    // Fill the pipeline: hold the receiver off while the sender keeps going.
    set_grid(15'd100, 15'd50, 15'd25, vgp_pkg::MODE_CENTER);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 200;
    for (int i = 0; i < 40; i++)
      send_voxel(pick_coord(reg_sx), pick_coord(reg_sy), pick_coord(reg_sz));

    drain();
    while (board.pending() != 0 && quiet_cycles < WATCHDOG) @(posedge clk);

    $display("sent %0d coordinate beats over all gradient modes and size extremes", sent);
    $display("checked %0d result beats under several stall patterns", board.checked);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("voxel_gradient_parameter verification clean");
    end else begin
      $display("voxel_gradient_parameter verification failed");
    end
    $finish;
  end
endmodule
